/* rtl/arh_pkg.sv */
package arh_pkg;

    localparam int BINS    = 2048;
    localparam int BIN_W   = $clog2(BINS);
    localparam int CNT_W   = 32;
    localparam int SMP_W   = 16;
    localparam int MAG_W   = SMP_W + 1;
    localparam int BPU_W   = 16;
    localparam int PROD_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int IDX_W   = PROD_W - FRAC_W;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [BPU_W-1:0]        BPU_RESET  = 16'd256;
    localparam logic signed [SMP_W-1:0] LOW_START  = 16'sh7FFF;
    localparam logic signed [SMP_W-1:0] HIGH_START = 16'sh8000;
    localparam logic [CNT_W-1:0]        CNT_MAX    = {CNT_W{1'b1}};
    localparam logic [IDX_W-1:0]        LAST_BIN   = IDX_W'(BINS - 1);

    localparam logic [APB_AW-3:0]       REG_BINS_PER_UNIT = '0;

    typedef enum logic [1:0] {
        OP_RANGE       = 2'd0,
        OP_HIST        = 2'd1,
        OP_READ        = 2'd2,
        OP_RANGE_RESET = 2'd3
    } op_t;

    typedef struct packed {
        logic                     valid;
        op_t                      op;
        logic signed [SMP_W-1:0]  sample;
        logic [BIN_W-1:0]         read_bin;
        logic signed [SMP_W-1:0]  range_min;
        logic signed [SMP_W-1:0]  range_max;
    } item_t;

    typedef struct packed {
        logic                     valid;
        logic signed [SMP_W-1:0]  range_min;
        logic signed [SMP_W-1:0]  range_max;
        logic [BIN_W-1:0]         bin_hit;
        logic [CNT_W-1:0]         bin_count;
        logic                     sample_skipped;
    } result_t;

endpackage

/* rtl/arh_bin_ram.sv */
module arh_bin_ram
    import arh_pkg::*;
(
    input  logic             aclk,
    input  logic             we,
    input  logic [BIN_W-1:0] waddr,
    input  logic [CNT_W-1:0] wdata,
    input  logic             re,
    input  logic [BIN_W-1:0] raddr,
    output logic [CNT_W-1:0] rdata
);

    logic [CNT_W-1:0] mem [BINS];
    logic [CNT_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/arh_range_unit.sv */
module arh_range_unit
    import arh_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    accept,
    input  op_t                     op,
    input  logic signed [SMP_W-1:0] sample,
    output logic signed [SMP_W-1:0] range_min,
    output logic signed [SMP_W-1:0] range_max
);

    logic signed [SMP_W-1:0] low_reg;
    logic signed [SMP_W-1:0] low_next;
    logic signed [SMP_W-1:0] high_reg;
    logic signed [SMP_W-1:0] high_next;

    always_comb begin
        low_next  = low_reg;
        high_next = high_reg;
        case (op)
            OP_RANGE: begin
                if (sample < low_reg) begin
                    low_next = sample;
                end
                if (sample > high_reg) begin
                    high_next = sample;
                end
            end
            OP_RANGE_RESET: begin
                low_next  = LOW_START;
                high_next = HIGH_START;
            end
            default: begin
                low_next  = low_reg;
                high_next = high_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg  <= LOW_START;
            high_reg <= HIGH_START;
        end else if (accept) begin
            low_reg  <= low_next;
            high_reg <= high_next;
        end
    end

    assign range_min = low_next;
    assign range_max = high_next;

`ifndef NO_ASSERTIONS
    a_range_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && op == OP_RANGE_RESET |=> low_reg == LOW_START && high_reg == HIGH_START)
        else $error("Range was not restored by a range reset transaction.");

    a_range_track: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && op == OP_RANGE |=> low_reg <= $past(sample) && high_reg >= $past(sample))
        else $error("Tracked range does not cover the last sample.");
`endif

endmodule

/* rtl/arh_hist_pipe.sv */
module arh_hist_pipe
    import arh_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  item_t            in_item,
    input  logic [BPU_W-1:0] bins_per_unit,
    output logic             clear_done,
    output result_t          result
);

    logic [BIN_W:0]      clr_cnt_reg;
    logic                clearing;

    item_t               s1_item_reg;
    logic                s1_zero_reg;
    logic [PROD_W-1:0]   s1_prod_reg;
    logic [MAG_W-1:0]    in_mag;
    logic [PROD_W-1:0]   in_prod;
    logic [IDX_W-1:0]    s1_idx_raw;
    logic [BIN_W-1:0]    s1_idx;
    logic [BIN_W-1:0]    s1_addr;
    logic                s1_uses;

    item_t               s2_item_reg;
    logic                s2_zero_reg;
    logic                s2_uses_reg;
    logic [BIN_W-1:0]    s2_addr_reg;
    logic                fwd_reg;
    logic [CNT_W-1:0]    fwd_data_reg;
    logic [CNT_W-1:0]    rdata;
    logic [CNT_W-1:0]    old_cnt;
    logic [CNT_W-1:0]    new_cnt;
    logic                s2_writes;
    logic                pipe_we;

    logic                ram_we;
    logic [BIN_W-1:0]    ram_waddr;
    logic [CNT_W-1:0]    ram_wdata;

    assign clearing   = !clr_cnt_reg[BIN_W];
    assign clear_done = clr_cnt_reg[BIN_W];

    assign in_mag  = in_item.sample[SMP_W-1] ? (~{in_item.sample[SMP_W-1], in_item.sample}
                     + MAG_W'(1)) : {1'b0, in_item.sample};
    assign in_prod = PROD_W'(in_mag) * PROD_W'(bins_per_unit);

    assign s1_idx_raw = s1_prod_reg[PROD_W-1:FRAC_W];
    assign s1_idx     = (s1_idx_raw > LAST_BIN) ? LAST_BIN[BIN_W-1:0] : s1_idx_raw[BIN_W-1:0];
    assign s1_addr    = (s1_item_reg.op == OP_READ) ? s1_item_reg.read_bin : s1_idx;
    assign s1_uses    = s1_item_reg.valid &&
                        ((s1_item_reg.op == OP_HIST && !s1_zero_reg) ||
                         s1_item_reg.op == OP_READ);

    assign old_cnt   = fwd_reg ? fwd_data_reg : rdata;
    assign new_cnt   = (s2_item_reg.op == OP_HIST) ?
                       ((old_cnt == CNT_MAX) ? old_cnt : old_cnt + CNT_W'(1)) : '0;
    assign s2_writes = s2_item_reg.valid && s2_uses_reg;
    assign pipe_we   = advance && s2_writes;

    assign ram_we    = clearing || pipe_we;
    assign ram_waddr = clearing ? clr_cnt_reg[BIN_W-1:0] : s2_addr_reg;
    assign ram_wdata = clearing ? '0 : new_cnt;

    arh_bin_ram u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (advance && s1_uses),
        .raddr (s1_addr),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (clearing) begin
            clr_cnt_reg <= clr_cnt_reg + (BIN_W + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_item_reg.valid <= 1'b0;
            s2_item_reg.valid <= 1'b0;
            fwd_reg           <= 1'b0;
        end else if (advance) begin
            s1_item_reg.valid     <= in_item.valid;
            s2_item_reg.valid     <= s1_item_reg.valid;
            fwd_reg               <= s1_uses && s2_writes && (s2_addr_reg == s1_addr);
            s1_item_reg.op        <= in_item.op;
            s1_item_reg.sample    <= in_item.sample;
            s1_item_reg.read_bin  <= in_item.read_bin;
            s1_item_reg.range_min <= in_item.range_min;
            s1_item_reg.range_max <= in_item.range_max;
            s1_zero_reg           <= (in_item.sample == '0);
            s1_prod_reg           <= in_prod;
            s2_item_reg.op        <= s1_item_reg.op;
            s2_item_reg.sample    <= s1_item_reg.sample;
            s2_item_reg.read_bin  <= s1_item_reg.read_bin;
            s2_item_reg.range_min <= s1_item_reg.range_min;
            s2_item_reg.range_max <= s1_item_reg.range_max;
            s2_zero_reg           <= s1_zero_reg;
            s2_uses_reg           <= s1_uses;
            s2_addr_reg           <= s1_addr;
            fwd_data_reg          <= new_cnt;
        end
    end

    always_comb begin
        result.valid          = s2_item_reg.valid;
        result.range_min      = s2_item_reg.range_min;
        result.range_max      = s2_item_reg.range_max;
        result.bin_hit        = s2_uses_reg ? s2_addr_reg : '0;
        result.bin_count      = '0;
        result.sample_skipped = 1'b0;
        case (s2_item_reg.op)
            OP_HIST: begin
                result.sample_skipped = s2_zero_reg;
                if (s2_uses_reg) begin
                    result.bin_count = new_cnt;
                end
            end
            OP_READ: begin
                result.bin_count = old_cnt;
            end
            default: begin
                result.bin_count = '0;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_no_write_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !pipe_we && !s1_item_reg.valid && !s2_item_reg.valid)
        else $error("Pipeline active while the bin store is being cleared.");

    a_fwd_has_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_reg |-> s2_item_reg.valid && s2_uses_reg)
        else $error("Forwarded count present without a stage that consumes it.");

    a_hist_write_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        pipe_we && s2_item_reg.op == OP_HIST |-> ram_wdata != '0)
        else $error("Histogram update wrote a zero count.");
`endif

endmodule

/* rtl/activation_range_histogram.sv */
// Channel   Direction  Contents
// s_ (in)   slave      tuser: operation; tdata: sample_value, read_bin
// m_ (out)  master     tuser: sample_skipped; tdata: range_min, range_max, bin_hit, bin_count
// apb       slave      bins_per_unit at byte address 0
//
// One transaction per cycle is taken while s_tready is high; it passes s1, s2 and out_reg.
// The rate is set by the single read port and single write port of the bin memory,
// with a forwarded count covering back-to-back updates of the same bin.
// After reset a clearing pass writes zero to all 2048 bins, one per cycle, while s_tready is low.
// A stalled output holds every stage; the input is taken while the output register drains.
module activation_range_histogram
    import arh_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,  // [15:0] sample_value, [26:16] read_bin
    input  logic [1:0]        s_tuser,  // [1:0] operation

    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [79:0]       m_tdata,  // [15:0] range_min, [31:16] range_max,
                                        // [42:32] bin_hit, [74:43] bin_count
    output logic              m_tuser,  // [0] sample_skipped

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [BPU_W-1:0]        bpu_reg;
    logic                    out_valid_reg;
    result_t                 out_reg;
    logic                    advance;
    logic                    accept;
    logic                    clear_done;
    logic signed [SMP_W-1:0] range_min;
    logic signed [SMP_W-1:0] range_max;
    item_t                   in_item;
    result_t                 result;

    assign pready   = 1'b1;
    assign prdata   = (paddr[APB_AW-1:2] == REG_BINS_PER_UNIT) ? APB_DW'(bpu_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpu_reg <= BPU_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr[APB_AW-1:2] == REG_BINS_PER_UNIT) begin
            bpu_reg <= pwdata[BPU_W-1:0];
        end
    end

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance && clear_done;
    assign accept   = s_tvalid && s_tready;

    arh_range_unit u_range (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .op        (op_t'(s_tuser)),
        .sample    (s_tdata[15:0]),
        .range_min (range_min),
        .range_max (range_max)
    );

    always_comb begin
        in_item.valid     = accept;
        in_item.op        = op_t'(s_tuser);
        in_item.sample    = s_tdata[15:0];
        in_item.read_bin  = s_tdata[16 +: BIN_W];
        in_item.range_min = range_min;
        in_item.range_max = range_max;
    end

    arh_hist_pipe u_hist (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (advance),
        .in_item       (in_item),
        .bins_per_unit (bpu_reg),
        .clear_done    (clear_done),
        .result        (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= result.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.bin_count, out_reg.bin_hit,
                       out_reg.range_max, out_reg.range_min};
    assign m_tuser  = out_reg.sample_skipped;

endmodule
